// ===== rtl/sukm_pkg.sv =====
// Package for the sorted unique-key max table: field widths, codes and the
// command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package sukm_pkg;

  localparam int unsigned ACT_W   = 2;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned GRADE_W = 32;
  localparam int unsigned RANK_W  = 11;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 12;
  localparam int unsigned ENTRY_W = KEY_W + GRADE_W;

  // Item actions
  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_READ   = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } act_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_KEY = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_RANK    = 2'd3
  } stat_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SEARCH,
    ST_SEARCH_CMP,
    ST_PROBE,
    ST_SHIFT,
    ST_PLACE,
    ST_READ_WAIT
  } ctrl_state_e;

  // Separate from the state enum so the finish state stays readable
  localparam ctrl_state_e ST_LAST = ST_READ_WAIT;

  // Commands from controller to datapath
  typedef struct packed {
    logic  load;         // capture the accepted item
    logic  srch_init;    // lo = 0, hi = count
    logic  srch_issue;   // read entry at mid
    logic  srch_step;    // narrow lo/hi on the returned key
    logic  probe_issue;  // read entry at the insert position
    logic  shift_init;   // shift index = count
    logic  shift_step;   // read idx-1, write it to idx next cycle
    logic  wr_entry;     // write {key, grade} at the insert position
    logic  count_inc;    // one more unique entry
    logic  read_issue;   // read entry at the requested rank
    logic  clear;        // empty the table
    logic  res_load;     // load the result register
    stat_e res_status;
    logic  res_take;     // result carries the read entry
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    act_e action;
    logic key_bad;     // key is zero or negative
    logic srch_done;   // lo == hi
    logic probe_ok;    // insert position lies below the count
    logic key_hit;     // probed key equals the item key
    logic grade_gt;    // item grade above the stored grade
    logic full;        // count at capacity
    logic shift_done;  // shift index reached the insert position
    logic rank_ok;     // rank below the count
  } sts_t;

endpackage

// ===== rtl/sukm_if.sv =====
// Valid/ready channel interfaces for the sorted unique-key max table.
// Depends on sukm_pkg.
`timescale 1ns / 1ps

interface sukm_in_if;
  logic                            valid;
  logic                            ready;
  logic [sukm_pkg::ACT_W-1:0]      action;
  logic signed [sukm_pkg::KEY_W-1:0]   key;
  logic signed [sukm_pkg::GRADE_W-1:0] grade;
  logic [sukm_pkg::RANK_W-1:0]     rank;

  modport source (output valid, action, key, grade, rank, input ready);
  modport sink   (input valid, action, key, grade, rank, output ready);
endinterface

interface sukm_out_if;
  logic                                valid;
  logic                                ready;
  logic [sukm_pkg::STAT_W-1:0]         status;
  logic [sukm_pkg::COUNT_W-1:0]        entry_count;
  logic signed [sukm_pkg::KEY_W-1:0]   entry_key;
  logic signed [sukm_pkg::GRADE_W-1:0] entry_grade;

  modport source (output valid, status, entry_count, entry_key, entry_grade, input ready);
  modport sink   (input valid, status, entry_count, entry_key, entry_grade, output ready);
endinterface

// ===== rtl/sukm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module sukm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ===== rtl/sukm_ctrl.sv =====
// Controller for the sorted unique-key max table: sequences search, shift,
// place and read, and owns the handshakes. Depends on sukm_pkg.
`timescale 1ns / 1ps

module sukm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  sukm_pkg::sts_t  sts_i,
  output sukm_pkg::cmd_t  cmd_o
);
  import sukm_pkg::*;

  ctrl_state_e state_q, state_d;
  stat_e       stat_q, stat_d;
  logic        take_q, take_d;
  logic        fin_q, fin_d;
  logic        out_valid_q, out_valid_d;

  // State and result bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stat_q      <= STAT_OK;
      take_q      <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stat_q      <= stat_d;
      take_q      <= take_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    stat_d     = stat_q;
    take_d     = take_q;
    fin_d      = fin_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;

    if (fin_q) begin
      // Item done: wait for a free output slot, then hand over the result
      if (!out_valid_q || out_ready_i) begin
        cmd_o.res_load = 1'b1;
        fin_d          = 1'b0;
        state_d        = ST_IDLE;
      end
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            state_d    = ST_DECODE;
          end
        end
        ST_DECODE: begin
          take_d = 1'b0;
          stat_d = STAT_OK;
          fin_d  = 1'b1;
          unique case (sts_i.action)
            ACT_INSERT: begin
              if (sts_i.key_bad) begin
                stat_d = STAT_BAD_KEY;
              end else begin
                cmd_o.srch_init = 1'b1;
                fin_d           = 1'b0;
                state_d         = ST_SEARCH;
              end
            end
            ACT_READ: begin
              if (sts_i.rank_ok) begin
                cmd_o.read_issue = 1'b1;
                fin_d            = 1'b0;
                state_d          = ST_READ_WAIT;
              end else begin
                stat_d = STAT_RANK;
              end
            end
            ACT_CLEAR: cmd_o.clear = 1'b1;
            ACT_NONE:  ;
          endcase
        end
        ST_SEARCH: begin
          if (!sts_i.srch_done) begin
            cmd_o.srch_issue = 1'b1;
            state_d          = ST_SEARCH_CMP;
          end else if (sts_i.probe_ok) begin
            cmd_o.probe_issue = 1'b1;
            state_d           = ST_PROBE;
          end else if (sts_i.full) begin
            stat_d = STAT_FULL;
            fin_d  = 1'b1;
          end else begin
            cmd_o.shift_init = 1'b1;
            state_d          = ST_SHIFT;
          end
        end
        ST_SEARCH_CMP: begin
          cmd_o.srch_step = 1'b1;
          state_d         = ST_SEARCH;
        end
        ST_PROBE: begin
          if (sts_i.key_hit) begin
            // Known key: keep the larger grade
            cmd_o.wr_entry = sts_i.grade_gt;
            fin_d          = 1'b1;
          end else if (sts_i.full) begin
            stat_d = STAT_FULL;
            fin_d  = 1'b1;
          end else begin
            cmd_o.shift_init = 1'b1;
            state_d          = ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          // Last moved entry is written in the cycle that sees shift_done
          if (sts_i.shift_done) begin
            state_d = ST_PLACE;
          end else begin
            cmd_o.shift_step = 1'b1;
          end
        end
        ST_PLACE: begin
          cmd_o.wr_entry  = 1'b1;
          cmd_o.count_inc = 1'b1;
          fin_d           = 1'b1;
        end
        ST_READ_WAIT: begin
          take_d = 1'b1;
          fin_d  = 1'b1;
        end
        default: state_d = ST_IDLE;
      endcase
    end

    cmd_o.res_status = stat_q;
    cmd_o.res_take   = take_q;
  end

  // Output valid: set on result load, dropped on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  // An accepted item always moves on to decode
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_DECODE))
    else $error("accepted item did not reach decode");

  // No new item while a finished one is still pending
  a_no_accept_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> !in_ready_o)
    else $error("input ready while a result is pending");

  // The walk never runs past the last state
  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LAST) |=> (state_q == ST_LAST || state_q == ST_IDLE))
    else $error("read wait did not finish");

endmodule

// ===== rtl/sukm_dp.sv =====
// Datapath for the sorted unique-key max table: item registers, search
// bounds, shift index, entry count, result register and the entry RAM.
// Depends on sukm_pkg and sukm_ram.
`timescale 1ns / 1ps

module sukm_dp #(
  parameter int unsigned CAPACITY = 2048
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sukm_pkg::cmd_t                      cmd_i,
  output sukm_pkg::sts_t                      sts_o,
  input  logic [sukm_pkg::ACT_W-1:0]          action_i,
  input  logic signed [sukm_pkg::KEY_W-1:0]   key_i,
  input  logic signed [sukm_pkg::GRADE_W-1:0] grade_i,
  input  logic [sukm_pkg::RANK_W-1:0]         rank_i,
  output logic [sukm_pkg::STAT_W-1:0]         status_o,
  output logic [sukm_pkg::COUNT_W-1:0]        entry_count_o,
  output logic signed [sukm_pkg::KEY_W-1:0]   entry_key_o,
  output logic signed [sukm_pkg::GRADE_W-1:0] entry_grade_o
);
  import sukm_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CW = CW'(CAPACITY);

  // Item registers
  logic [ACT_W-1:0]          act_q;
  logic signed [KEY_W-1:0]   key_q;
  logic signed [GRADE_W-1:0] grade_q;
  logic [RANK_W-1:0]         rank_q;

  // Walk registers
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] lo_q, lo_d;
  logic [CW-1:0] hi_q, hi_d;
  logic [CW-1:0] mid_q, mid_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          wr_pend_q;
  logic [AW-1:0] wa_q;

  // Result register
  logic [STAT_W-1:0]         res_status_q;
  logic [COUNT_W-1:0]        res_count_q;
  logic signed [KEY_W-1:0]   res_key_q;
  logic signed [GRADE_W-1:0] res_grade_q;

  // RAM ports
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_wa, ram_ra;
  logic [ENTRY_W-1:0] ram_wd, ram_rd;
  logic [KEY_W-1:0]   rd_key;
  logic [GRADE_W-1:0] rd_grade;

  // Width helpers
  logic [CW:0]            mid_sum;
  logic [AW+RANK_W-1:0]   rank_ext;
  logic [CW+RANK_W-1:0]   rank_cmp, count_cmp;
  logic [CW+COUNT_W-1:0]  count_wide;
  logic [CW-1:0]          idx_m1;

  assign rd_key   = ram_rd[ENTRY_W-1:GRADE_W];
  assign rd_grade = ram_rd[GRADE_W-1:0];

  assign mid_sum    = ({1'b0, lo_q} + {1'b0, hi_q}) >> 1;
  assign rank_ext   = {{AW{1'b0}}, rank_q};
  assign rank_cmp   = {{CW{1'b0}}, rank_q};
  assign count_cmp  = {{RANK_W{1'b0}}, count_q};
  assign count_wide = {{COUNT_W{1'b0}}, count_d};
  assign idx_m1     = idx_q - CW'(1);

  // Status towards the controller
  always_comb begin
    sts_o.action     = act_e'(act_q);
    sts_o.key_bad    = (key_q == '0) || key_q[KEY_W-1];
    sts_o.srch_done  = (lo_q == hi_q);
    sts_o.probe_ok   = (lo_q < count_q);
    sts_o.key_hit    = (rd_key == key_q);
    sts_o.grade_gt   = (grade_q > $signed(rd_grade));
    sts_o.full       = (count_q == CAP_CW);
    sts_o.shift_done = (idx_q == lo_q);
    sts_o.rank_ok    = (rank_cmp < count_cmp);
  end

  // Search bounds, shift index and count
  always_comb begin
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    idx_d   = idx_q;
    count_d = count_q;
    if (cmd_i.srch_init) begin
      lo_d = '0;
      hi_d = count_q;
    end
    if (cmd_i.srch_issue) begin
      mid_d = mid_sum[CW-1:0];
    end
    if (cmd_i.srch_step) begin
      // Keys are positive, so an unsigned compare orders them
      if (rd_key < key_q) begin
        lo_d = mid_q + CW'(1);
      end else begin
        hi_d = mid_q;
      end
    end
    if (cmd_i.shift_init) begin
      idx_d = count_q;
    end
    if (cmd_i.shift_step) begin
      idx_d = idx_m1;
    end
    if (cmd_i.clear) begin
      count_d = '0;
    end
    if (cmd_i.count_inc) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
      mid_q     <= '0;
      idx_q     <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      mid_q     <= mid_d;
      idx_q     <= idx_d;
      wr_pend_q <= cmd_i.shift_step;
    end
  end

  // Item capture, shift write address and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q   <= action_i;
      key_q   <= key_i;
      grade_q <= grade_i;
      rank_q  <= rank_i;
    end
    wa_q <= idx_q[AW-1:0];
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_count_q  <= count_wide[COUNT_W-1:0];
      res_key_q    <= cmd_i.res_take ? $signed(rd_key) : '0;
      res_grade_q  <= cmd_i.res_take ? $signed(rd_grade) : '0;
    end
  end

  // Read port: one address a cycle, chosen by the current command
  always_comb begin
    ram_re = cmd_i.srch_issue | cmd_i.probe_issue | cmd_i.shift_step | cmd_i.read_issue;
    priority if (cmd_i.srch_issue) begin
      ram_ra = mid_sum[AW-1:0];
    end else if (cmd_i.probe_issue) begin
      ram_ra = lo_q[AW-1:0];
    end else if (cmd_i.shift_step) begin
      ram_ra = idx_m1[AW-1:0];
    end else begin
      ram_ra = rank_ext[AW-1:0];
    end
  end

  // Write port: a pending shift move, or the item entry at the insert position
  always_comb begin
    ram_we = wr_pend_q | cmd_i.wr_entry;
    if (wr_pend_q) begin
      ram_wa = wa_q;
      ram_wd = ram_rd;
    end else begin
      ram_wa = lo_q[AW-1:0];
      ram_wd = {key_q, grade_q};
    end
  end

  sukm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_entry_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_wa),
    .wr_data_i (ram_wd),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_ra),
    .rd_data_o (ram_rd)
  );

  assign status_o      = res_status_q;
  assign entry_count_o = res_count_q;
  assign entry_key_o   = res_key_q;
  assign entry_grade_o = res_grade_q;

  // Count never passes capacity
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_CW)
    else $error("entry count above capacity");

  // A shift move and an entry write never share the write port
  a_wr_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_pend_q && cmd_i.wr_entry))
    else $error("write port clash");

  // A new entry only goes into a table with room
  a_place_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.count_inc |-> (count_q < CAP_CW))
    else $error("entry placed into a full table");

  // Search narrowing only while the bounds are open
  a_srch_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.srch_step |-> (lo_q < hi_q) && (hi_q <= count_q))
    else $error("search step on closed bounds");

endmodule

// ===== rtl/sorted_unique_key_max_table_core.sv =====
// Top level of the sorted unique-key max table.
// Depends on sukm_pkg, sukm_if, sukm_ctrl and sukm_dp (with sukm_ram).
//
//   channel  dir  fields                                    transfer
//   in_i     in   action, key, grade, rank                  valid & ready
//   out_o    out  status, entry_count, entry_key, entry_grade  valid & ready
//
// One item at a time; every item gives one result. Binary search and the
// entry shift both go through the single read port of the entry RAM; the
// shift moves one entry a cycle. Reset empties the table at once; entries
// are never cleared.
// A new item is taken while the previous result still waits in the output
// register; a stalled output holds the following result back at its end.
`timescale 1ns / 1ps

module sorted_unique_key_max_table_core #(
  parameter int unsigned CAPACITY = 2048
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sukm_in_if.sink    in_i,
  sukm_out_if.source out_o
);
  import sukm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sukm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sukm_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .action_i      (in_i.action),
    .key_i         (in_i.key),
    .grade_i       (in_i.grade),
    .rank_i        (in_i.rank),
    .status_o      (out_o.status),
    .entry_count_o (out_o.entry_count),
    .entry_key_o   (out_o.entry_key),
    .entry_grade_o (out_o.entry_grade)
  );

endmodule

// ===== tb/sv/tb_sorted_unique_key_max_table_core.sv =====
// Self-checking testbench for sorted_unique_key_max_table_core: directed and random
// items are checked against a behavioural table kept in a scoreboard class.
// Depends on sukm_pkg, sukm_if and the core RTL.
`timescale 1ns / 1ps

module tb_sorted_unique_key_max_table_core;
  import sukm_pkg::*;

  localparam int unsigned TABLE_DEPTH     = 2048;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS    = 250;
  localparam int unsigned POOL_LIMIT      = 48;

  typedef struct {
    act_e                      action;
    logic signed [KEY_W-1:0]   key;
    logic signed [GRADE_W-1:0] grade;
    logic [RANK_W-1:0]         rank;
  } table_item_t;

  typedef struct {
    stat_e                     status;
    logic [COUNT_W-1:0]        count;
    logic signed [KEY_W-1:0]   key;
    logic signed [GRADE_W-1:0] grade;
  } table_reply_t;

  // Behavioural copy of the table plus the replies still owed by the block
  class table_scoreboard #(int unsigned CAP = 2048);
    logic signed [KEY_W-1:0]   key_mem   [CAP];
    logic signed [GRADE_W-1:0] grade_mem [CAP];
    int unsigned               held;
    table_reply_t              replies_due [$];
    int unsigned               errors;

    function table_reply_t update_table(table_item_t it);
      table_reply_t r;
      int unsigned  lo, hi, mid, i;
      r.status = STAT_OK;
      r.key    = '0;
      r.grade  = '0;
      case (it.action)
        ACT_INSERT: begin
          if (it.key <= 0) begin
            r.status = STAT_BAD_KEY;
          end else begin
            // first slot whose key is not below the new one
            lo = 0;
            hi = held;
            while (lo < hi) begin
              mid = (lo + hi) / 2;
              if (key_mem[mid] < it.key) lo = mid + 1;
              else hi = mid;
            end
            if (lo < held && key_mem[lo] == it.key) begin
              if (it.grade > grade_mem[lo]) grade_mem[lo] = it.grade;
            end else if (held >= CAP) begin
              r.status = STAT_FULL;
            end else begin
              for (i = held; i > lo; i--) begin
                key_mem[i]   = key_mem[i-1];
                grade_mem[i] = grade_mem[i-1];
              end
              key_mem[lo]   = it.key;
              grade_mem[lo] = it.grade;
              held++;
            end
          end
        end
        ACT_READ: begin
          if (it.rank < held) begin
            r.key   = key_mem[it.rank];
            r.grade = grade_mem[it.rank];
          end else begin
            r.status = STAT_RANK;
          end
        end
        ACT_CLEAR: held = 0;
        default: ;
      endcase
      r.count = COUNT_W'(held);
      return r;
    endfunction

    function void note_item(table_item_t it);
      replies_due.push_back(update_table(it));
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(table_reply_t got);
      table_reply_t want;
      if (replies_due.size() == 0) begin
        report($sformatf("reply with nothing outstanding: status %0d count %0d",
                         got.status, got.count));
        return;
      end
      want = replies_due.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.count !== want.count)
        report($sformatf("entry_count %0d, expected %0d", got.count, want.count));
      if (got.key !== want.key)
        report($sformatf("entry_key %h, expected %h", got.key, want.key));
      if (got.grade !== want.grade)
        report($sformatf("entry_grade %h, expected %h", got.grade, want.grade));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  bit   no_idle;
  bit   long_hold_req;

  sukm_in_if  in_ch ();
  sukm_out_if out_ch ();

  table_scoreboard #(TABLE_DEPTH) sb;

  // keys inserted since the last clear, used to aim reads and repeat inserts
  int key_pool [$];
  bit pooled [int];

  sorted_unique_key_max_table_core #(
    .CAPACITY(TABLE_DEPTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // 20 ns clock
  always #10 clk_i = ~clk_i;

  // Record every input transfer and check every output transfer
  always @(posedge clk_i) begin : monitor
    table_item_t  it;
    table_reply_t rp;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        it.action = act_e'(in_ch.action);
        it.key    = in_ch.key;
        it.grade  = in_ch.grade;
        it.rank   = in_ch.rank;
        sb.note_item(it);
      end
      if (out_ch.valid && out_ch.ready) begin
        rp.status = stat_e'(out_ch.status);
        rp.count  = out_ch.entry_count;
        rp.key    = out_ch.entry_key;
        rp.grade  = out_ch.entry_grade;
        sb.check_result(rp);
      end
    end
  end

  // Result side: random stalls per transfer, one long hold on request
  initial begin : receiver
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        long_hold_req = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // Watchdog
  initial begin : watchdog
    #100_000_000;
    $display("sorted_unique_key_max_table_core test failed");
    $finish;
  end

  // Offer one item after a random gap and hold it until the transfer
  task automatic send_item(input act_e act, input logic signed [KEY_W-1:0] k,
                           input logic signed [GRADE_W-1:0] g,
                           input logic [RANK_W-1:0] r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.action <= act;
    in_ch.key    <= k;
    in_ch.grade  <= g;
    in_ch.rank   <= r;
    in_ch.valid  <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Withdraw the offer and wait until every owed reply has been checked
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.replies_due.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic forget_pool();
    key_pool.delete();
    pooled.delete();
  endtask

  // One random item; the table is cleared now and then to keep inserts short
  task automatic send_random_item();
    int unsigned               pick, sub;
    logic signed [KEY_W-1:0]   k;
    logic signed [GRADE_W-1:0] g;
    logic [RANK_W-1:0]         r;
    pick = $urandom_range(0, 99);
    sub  = $urandom_range(0, 99);
    g    = (sub < 50) ? $urandom_range(0, 1024) - 512 : $urandom();
    k    = $urandom();
    r    = RANK_W'($urandom());
    if (key_pool.size() >= POOL_LIMIT || pick < 4) begin
      send_item(ACT_CLEAR, k, g, r);
      forget_pool();
    end else if (pick < 7) begin
      send_item(ACT_NONE, k, g, r);
    end else if (pick < 60) begin
      sub = $urandom_range(0, 99);
      if (sub < 12) begin
        // refused keys: zero, minus one, most negative, any negative
        case ($urandom_range(0, 3))
          0: k = 0;
          1: k = -1;
          2: k = 32'sh8000_0000;
          default: k = $urandom() | 32'h8000_0000;
        endcase
      end else if (sub < 45 && key_pool.size() > 0) begin
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end else if (sub < 80) begin
        k = $urandom_range(1, 200);
      end else begin
        k = $urandom_range(32'h7FFF_FFFF, 1);
      end
      send_item(ACT_INSERT, k, g, r);
      if (k > 0 && !pooled.exists(k)) begin
        pooled[k] = 1'b1;
        key_pool.push_back(k);
      end
    end else begin
      sub = $urandom_range(0, 99);
      if (sub < 75 && key_pool.size() > 0)
        r = RANK_W'($urandom_range(0, key_pool.size() - 1));
      else if (sub < 90)
        r = RANK_W'(key_pool.size() + $urandom_range(0, 3));
      send_item(ACT_READ, k, g, r);
    end
  endtask

  initial begin : stimulus
    int i;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    no_idle       = 1'b0;
    long_hold_req = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.action  = ACT_NONE;
    in_ch.key     = '0;
    in_ch.grade   = '0;
    in_ch.rank    = '0;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty reads, refused keys, extreme keys and grades, ties
    send_item(ACT_READ,   0, 0, 0);
    send_item(ACT_INSERT, 0, 32'sd100, 0);
    send_item(ACT_INSERT, -1, 32'sd100, 0);
    send_item(ACT_INSERT, 32'sh8000_0000, 32'sd100, 0);
    send_item(ACT_INSERT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
    send_item(ACT_INSERT, 1, 32'sh8000_0000, 0);
    send_item(ACT_INSERT, 100, 5, 0);
    send_item(ACT_INSERT, 100, 5, 0);
    send_item(ACT_INSERT, 100, 4, 0);
    send_item(ACT_INSERT, 100, -1, 0);
    send_item(ACT_INSERT, 100, 32'sh200, 0);
    send_item(ACT_INSERT, 1, 32'sh8000_0001, 0);
    send_item(ACT_INSERT, 50, -256, 0);
    send_item(ACT_READ,   0, 0, 0);
    send_item(ACT_READ,   0, 0, 1);
    send_item(ACT_READ,   0, 0, 2);
    send_item(ACT_READ,   0, 0, 3);
    send_item(ACT_READ,   0, 0, 4);
    send_item(ACT_READ,   0, 0, 11'h7FF);
    send_item(ACT_NONE,   32'h5A5A_A5A5, 32'hA5A5_5A5A, 11'h555);
    send_item(ACT_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'h7FF);
    send_item(ACT_READ,   0, 0, 0);
    wait_drained();

    // Random traffic, with one long output hold and one stretch without gaps
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 100) begin
        wait_drained();
        long_hold_req = 1'b1;
        no_idle = 1'b1;
        repeat (12) send_random_item();
      end
      if (i == 200) wait_drained();
      no_idle = (i >= 100 && i < 150);
      send_random_item();
    end
    no_idle = 1'b0;

    // Empty the table and read it back
    send_item(ACT_CLEAR,  0, 0, 0);
    send_item(ACT_READ,   0, 0, 0);
    forget_pool();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("sorted_unique_key_max_table_core test passed");
    end else begin
      $display("sorted_unique_key_max_table_core test failed");
    end
    $finish;
  end

endmodule
